[design/ordered_integer_list_engine_macros.svh]
// ----------------------------------------------------------------------------
// Ordered integer list engine: assertion macros
// Immediate-consequence and next-cycle checks, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_INTEGER_LIST_ENGINE_MACROS_SVH
`define ORDERED_INTEGER_LIST_ENGINE_MACROS_SVH

`define OILE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("List engine check failed.");

`define OILE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("List engine check failed.");

`endif

[design/oile_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered integer list engine package
// Shared types, request and status codes, and controller interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package oile_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = 7;

    typedef enum logic [2:0] {
        REQ_APPEND  = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_DEL_VAL = 3'd2,
        REQ_DEL_IDX = 3'd3,
        REQ_REVERSE = 3'd4,
        REQ_READ    = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_value;
        logic [6:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [2:0]         status;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_INS_CHK, S_INS_WR, S_SRCH_RD, S_SRCH_CMP,
        S_DN_CHK, S_DN_WR, S_REV_RD_LO, S_REV_RD_HI, S_REV_WR_LO,
        S_REV_WR_HI, S_RD_ISSUE, S_RD_EMIT, S_EMIT
    } t_state;

    typedef enum logic [1:0] {A_IDX, A_IDXM1, A_IDXP1, A_HI} t_rsel;
    typedef enum logic [1:0] {D_VAL, D_RDATA, D_TMP} t_dsel;
    typedef enum logic [2:0] {
        IDX_HOLD, IDX_ZERO, IDX_COUNT, IDX_POS, IDX_INC, IDX_DEC
    } t_idx_op;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} t_cnt_op;

    typedef struct packed {
        logic       latch;
        logic       rd_en;
        t_rsel      rd_sel;
        logic       wr_en;
        logic       wr_hi;
        t_dsel      wr_data;
        t_idx_op    idx_op;
        logic       hi_load;
        logic       hi_dec;
        logic       tmp_ld;
        t_cnt_op    cnt_op;
        logic       out_ld;
        logic       out_elem;
        logic [2:0] out_status;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic [2:0]    req_type;
        logic [CW-1:0] count;
        logic          count_zero;
        logic          count_full;
        logic          count_le1;
        logic          pos_ge_count;
        logic          idx_gt_tgt;
        logic          idx_eq_count;
        logic          idx_p1_lt_count;
        logic          idx_lt_hi;
        logic          is_last;
        logic          match;
        logic          out_free;
    } t_stat;

endpackage

`default_nettype wire

[design/oile_datapath.sv]
// ----------------------------------------------------------------------------
// Ordered integer list engine datapath
// Element store, count, walk pointers, request latch and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oile_datapath
    import oile_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rdata;
    logic [31:0]   r_tmp;
    t_in_item      r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_hi;
    logic          r_ovalid;
    t_out_item     r_oitem;

    logic [CW-1:0] w_idx_p1;
    logic [CW-1:0] w_idx_m1;
    logic [CW-1:0] w_tgt;
    logic [CW-1:0] w_raddr;
    logic [CW-1:0] w_waddr;
    logic [31:0]   w_wdata;

    assign w_idx_p1 = r_idx + CW'(1);
    assign w_idx_m1 = r_idx - CW'(1);

    always_comb begin
        if (r_req.req_type == REQ_APPEND || r_req.position > r_count) begin
            w_tgt = r_count;
        end else begin
            w_tgt = r_req.position;
        end
        case (i_cmd.rd_sel)
            A_IDX:   w_raddr = r_idx;
            A_IDXM1: w_raddr = w_idx_m1;
            A_IDXP1: w_raddr = w_idx_p1;
            A_HI:    w_raddr = r_hi;
            default: w_raddr = r_idx;
        endcase
        w_waddr = i_cmd.wr_hi ? r_hi : r_idx;
        case (i_cmd.wr_data)
            D_VAL:   w_wdata = r_req.item_value;
            D_RDATA: w_wdata = r_rdata;
            D_TMP:   w_wdata = r_tmp;
            default: w_wdata = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr[AW-1:0]];
        end
        if (i_cmd.tmp_ld) begin
            r_tmp <= r_rdata;
        end
        if (i_cmd.latch) begin
            r_req <= i_item;
        end
        case (i_cmd.idx_op)
            IDX_ZERO:  r_idx <= '0;
            IDX_COUNT: r_idx <= r_count;
            IDX_POS:   r_idx <= r_req.position;
            IDX_INC:   r_idx <= w_idx_p1;
            IDX_DEC:   r_idx <= w_idx_m1;
            default:   r_idx <= r_idx;
        endcase
        if (i_cmd.hi_load) begin
            r_hi <= r_count - CW'(1);
        end else if (i_cmd.hi_dec) begin
            r_hi <= r_hi - CW'(1);
        end
        if (i_cmd.out_ld) begin
            r_oitem.out_value <= i_cmd.out_elem ? r_rdata : '0;
            r_oitem.status    <= i_cmd.out_status;
            r_oitem.last      <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_INC: r_count <= r_count + CW'(1);
                CNT_DEC: r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.req_type        = r_req.req_type;
        o_stat.count           = r_count;
        o_stat.count_zero      = (r_count == '0);
        o_stat.count_full      = (r_count >= CW'(CAPACITY));
        o_stat.count_le1       = (r_count <= CW'(1));
        o_stat.pos_ge_count    = (r_req.position >= r_count);
        o_stat.idx_gt_tgt      = (r_idx > w_tgt);
        o_stat.idx_eq_count    = (r_idx == r_count);
        o_stat.idx_p1_lt_count = (w_idx_p1 < r_count);
        o_stat.idx_lt_hi       = (r_idx < r_hi);
        o_stat.is_last         = (w_idx_p1 == r_count);
        o_stat.match           = (r_rdata == r_req.item_value);
        o_stat.out_free        = !r_ovalid || i_ready;
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

endmodule

`default_nettype wire

[design/oile_ctrl.sv]
// ----------------------------------------------------------------------------
// Ordered integer list engine controller
// Sequences each request as reads, writes and pointer steps on the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module oile_ctrl
    import oile_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_st;
    logic [2:0] n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        o_cmd.rd_sel  = A_IDX;
        o_cmd.wr_data = D_RDATA;
        o_cmd.idx_op  = IDX_HOLD;
        o_cmd.cnt_op  = CNT_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_st    = ST_OK;
                n_state = S_EMIT;
                case (i_stat.req_type)
                    REQ_APPEND, REQ_INSERT: begin
                        if (i_stat.count_full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = S_INS_CHK;
                        end
                    end
                    REQ_DEL_VAL: begin
                        if (i_stat.count_zero) begin
                            n_st = ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_SRCH_RD;
                        end
                    end
                    REQ_DEL_IDX: begin
                        if (i_stat.count_zero) begin
                            n_st = ST_EMPTY;
                        end else if (i_stat.pos_ge_count) begin
                            n_st = ST_RANGE;
                        end else begin
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_DN_CHK;
                        end
                    end
                    REQ_REVERSE: begin
                        if (!i_stat.count_le1) begin
                            o_cmd.idx_op  = IDX_ZERO;
                            o_cmd.hi_load = 1'b1;
                            n_state       = S_REV_RD_LO;
                        end
                    end
                    REQ_READ: begin
                        if (i_stat.count_zero) begin
                            n_st = ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_RD_ISSUE;
                        end
                    end
                    default: begin
                        n_st = ST_OK;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (i_stat.idx_gt_tgt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IDXM1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_data = D_VAL;
                    o_cmd.cnt_op  = CNT_INC;
                    n_st          = ST_OK;
                    n_state       = S_EMIT;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_INS_CHK;
            end
            S_SRCH_RD: begin
                if (i_stat.idx_eq_count) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    n_state = S_DN_CHK;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_SRCH_RD;
                end
            end
            S_DN_CHK: begin
                if (i_stat.idx_p1_lt_count) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IDXP1;
                    n_state      = S_DN_WR;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_st         = ST_OK;
                    n_state      = S_EMIT;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_DN_CHK;
            end
            S_REV_RD_LO: begin
                if (i_stat.idx_lt_hi) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_REV_RD_HI;
                end else begin
                    n_st    = ST_OK;
                    n_state = S_EMIT;
                end
            end
            S_REV_RD_HI: begin
                o_cmd.tmp_ld = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = A_HI;
                n_state      = S_REV_WR_LO;
            end
            S_REV_WR_LO: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_REV_WR_HI;
            end
            S_REV_WR_HI: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_hi   = 1'b1;
                o_cmd.wr_data = D_TMP;
                o_cmd.idx_op  = IDX_INC;
                o_cmd.hi_dec  = 1'b1;
                n_state       = S_REV_RD_LO;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.out_elem   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_last   = i_stat.is_last;
                    o_cmd.idx_op     = IDX_INC;
                    n_state          = i_stat.is_last ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.out_status = r_st;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[design/ordered_integer_list_engine.sv]
// ----------------------------------------------------------------------------
// Ordered integer list engine
// Keeps an ordered list of signed 32-bit values and serves list requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. Insert and delete shift elements
// through the element store, reading each moved element and then writing
// it; delete by value first searches with a read and a compare per element.
// Reverse swaps pairs with a read of each end, then a write of each end;
// read-out reads each element and emits it when the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_integer_list_engine_macros.svh"

module ordered_integer_list_engine
    import oile_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);

    t_cmd  w_cmd;
    t_stat w_stat;

    oile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    oile_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    `OILE_ASSERT_IMP(a_count_bound, 1'b1, w_stat.count <= CW'(CAPACITY))
    `OILE_ASSERT_IMP(a_no_write_on_emit, w_cmd.wr_en, !w_cmd.out_ld)
    `OILE_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

endmodule

`default_nettype wire

[dv/tb_ordered_integer_list_engine.sv]
// ----------------------------------------------------------------------------
// Ordered integer list engine testbench
// Drives directed and random list requests with random idling on both sides,
// predicts every result with a behavioral list, and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_integer_list_engine;
    import oile_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    ordered_integer_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    t_in_item  pending_requests[$];
    t_out_item expected_results[$];
    logic signed [31:0] list_model[$];
    int  mismatches;
    int  hold_off_cycles;
    bit  calm_phase;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic void push_status(input logic [2:0] st);
        t_out_item r;
        r.out_value = '0;
        r.status    = st;
        r.last      = 1'b1;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_list_request(input t_in_item req);
        t_out_item r;
        int        n;
        int        p;
        bit        found;
        n = list_model.size();
        p = int'(req.position);
        found = 1'b0;
        case (req.req_type)
            REQ_APPEND, REQ_INSERT: begin
                if (n >= CAPACITY) begin
                    push_status(ST_FULL);
                end else begin
                    if (req.req_type == REQ_APPEND || p > n) p = n;
                    list_model.insert(p, req.item_value);
                    push_status(ST_OK);
                end
            end
            REQ_DEL_VAL: begin
                if (n == 0) begin
                    push_status(ST_EMPTY);
                end else begin
                    for (int i = 0; i < n && !found; i++) begin
                        if (list_model[i] == req.item_value) begin
                            list_model.delete(i);
                            found = 1'b1;
                        end
                    end
                    push_status(found ? ST_OK : ST_NOT_FOUND);
                end
            end
            REQ_DEL_IDX: begin
                if (n == 0) begin
                    push_status(ST_EMPTY);
                end else if (p >= n) begin
                    push_status(ST_RANGE);
                end else begin
                    list_model.delete(p);
                    push_status(ST_OK);
                end
            end
            REQ_REVERSE: begin
                list_model.reverse();
                push_status(ST_OK);
            end
            REQ_READ: begin
                if (n == 0) begin
                    push_status(ST_EMPTY);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        r.out_value = list_model[i];
                        r.status    = ST_OK;
                        r.last      = (i == n - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: push_status(ST_OK);
        endcase
    endfunction

    // Driver: predicts at acceptance, so the model tracks the block's order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_list_request(i_item);
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() > 0 && pending_requests[0].req_type === 3'bx) begin
                    i_valid <= 1'b0;
                    if (!(i_valid && o_ready) && expected_results.size() == 0) begin
                        void'(pending_requests.pop_front());
                    end
                end else if (pending_requests.size() > 0 &&
                             (calm_phase || $urandom_range(99) >= 35)) begin
                    i_item  <= pending_requests.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result: value %0d status %0d last %0d",
                                 o_item.out_value, o_item.status, o_item.last);
                    end
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (o_item.out_value !== e.out_value || o_item.status !== e.status ||
                        o_item.last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.out_value, e.status, e.last,
                                     o_item.out_value, o_item.status, o_item.last);
                        end
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm_phase || ($urandom_range(99) >= 35);
            end
        end
    end

    function automatic t_in_item make_request(input logic [2:0] rt,
                                              input logic [31:0] v,
                                              input logic [6:0] p);
        t_in_item r;
        r.req_type   = rt;
        r.item_value = v;
        r.position   = p;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(15);
        endcase
    endfunction

    function automatic t_in_item make_pause();
        t_in_item r;
        r = 'x;
        return r;
    endfunction

    initial begin
        logic [2:0] rt;
        int w;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_item  = '0;
        mismatches = 0;
        hold_off_cycles = 0;
        calm_phase = 1'b0;

        // Empty-list cases, extremes, head insert, insert past end.
        pending_requests.push_back(make_request(REQ_READ, 0, 0));
        pending_requests.push_back(make_request(REQ_DEL_VAL, 5, 0));
        pending_requests.push_back(make_request(REQ_DEL_IDX, 0, 0));
        pending_requests.push_back(make_request(REQ_REVERSE, 0, 0));
        pending_requests.push_back(make_request(REQ_APPEND, 32'h8000_0000, 7'h7F));
        pending_requests.push_back(make_request(REQ_APPEND, 32'h7FFF_FFFF, 0));
        pending_requests.push_back(make_request(REQ_INSERT, 32'hFFFF_FFFF, 0));
        pending_requests.push_back(make_request(REQ_INSERT, 3, 7'h7F));
        pending_requests.push_back(make_request(REQ_INSERT, 9, 2));
        pending_requests.push_back(make_request(REQ_READ, 0, 0));
        pending_requests.push_back(make_request(REQ_REVERSE, 0, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0));
        pending_requests.push_back(make_request(REQ_DEL_VAL, 42, 0));
        pending_requests.push_back(make_request(REQ_DEL_VAL, 9, 0));
        pending_requests.push_back(make_request(REQ_DEL_IDX, 7'h7F, 7'h7F));
        pending_requests.push_back(make_request(REQ_DEL_IDX, 0, 3));
        pending_requests.push_back(make_request(REQ_DEL_IDX, 0, 0));
        pending_requests.push_back(make_request(3'd6, 32'h5555_AAAA, 7'h55));
        pending_requests.push_back(make_request(3'd7, 32'hAAAA_5555, 7'h2A));
        pending_requests.push_back(make_request(REQ_READ, 0, 0));
        pending_requests.push_back(make_pause());
        // Fill past capacity to reach the full status.
        for (int i = 0; i < CAPACITY + 2; i++) begin
            pending_requests.push_back(make_request(i[0] ? REQ_INSERT : REQ_APPEND,
                                                    pick_value(), 7'($urandom_range(127))));
        end
        pending_requests.push_back(make_request(REQ_READ, 0, 0));
        pending_requests.push_back(make_request(REQ_REVERSE, 0, 0));
        pending_requests.push_back(make_request(REQ_READ, 0, 0));
        for (int i = 0; i < 200; i++) begin
            w = $urandom_range(99);
            if (w < 22)      rt = REQ_APPEND;
            else if (w < 40) rt = REQ_INSERT;
            else if (w < 58) rt = REQ_DEL_VAL;
            else if (w < 76) rt = REQ_DEL_IDX;
            else if (w < 84) rt = REQ_REVERSE;
            else if (w < 96) rt = REQ_READ;
            else             rt = 3'($urandom_range(7));
            pending_requests.push_back(make_request(rt, pick_value(),
                $urandom_range(3) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(20))));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A stretch with no idling at all.
        wait (pending_requests.size() < 150);
        @(posedge i_clk);
        calm_phase <= 1'b1;
        wait (pending_requests.size() < 90);
        @(posedge i_clk);
        calm_phase <= 1'b0;
        // Long receiver hold-off while the sender keeps offering.
        wait (pending_requests.size() < 60);
        @(posedge i_clk);
        hold_off_cycles <= 600;

        wait (pending_requests.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (2 * CAPACITY + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ordered_integer_list_engine: match");
        end else begin
            $display("ordered_integer_list_engine: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("ordered_integer_list_engine: mismatch");
        $finish;
    end

endmodule
